// ===== sv/chht_pkg.sv =====
// Shared types and constants for the callsign hash table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package chht_pkg;

    localparam int HEAD_W   = 64;
    localparam int TAIL_W   = 24;
    localparam int HASH_W   = 22;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;
    localparam int HOME_W   = 10;
    localparam int HOME_MULT = 23;
    // 10-bit home key times 23 stays below 2**15
    localparam int PROD_W   = 15;

    localparam int DEFAULT_TABLE_ENTRIES = 256;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_10 = 2'd0,
        KIND_12 = 2'd1,
        KIND_22 = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_CLEARED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [TAIL_W-1:0] tail;
        logic [HASH_W-1:0] hash;
    } entry_t;

endpackage

`default_nettype wire

// ===== sv/chht_home.sv =====
// Home slot unit: key * 23 modulo the table size on one shared multiplier,
// using a reciprocal quotient estimate and one correcting subtract. Uses chht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chht_home #(
    parameter int TABLE_ENTRIES = chht_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [chht_pkg::HOME_W-1:0]        key,
    output logic                                    done,
    output logic [$clog2(TABLE_ENTRIES)-1:0]        slot
);
    import chht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int MUL_W = 2 * PROD_W;
    // floor(2**PROD_W / TABLE_ENTRIES): quotient estimate is exact or one low
    localparam int RECIP = (1 << PROD_W) / TABLE_ENTRIES;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_RECIP = 4'b0010,
        PH_BACK  = 4'b0100,
        PH_FIX   = 4'b1000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] quot_reg, quot_next;
    logic [PROD_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_b;
    logic [MUL_W-1:0]  mul_p;

    // shared multiplier: key * 23, then product * reciprocal, then quotient * size
    always_comb
    begin
        mul_a = PROD_W'(key);
        mul_b = PROD_W'(HOME_MULT);
        case (phase_reg)
            PH_RECIP:
            begin
                mul_a = acc_reg;
                mul_b = PROD_W'(RECIP);
            end
            PH_BACK:
            begin
                mul_a = quot_reg;
                mul_b = PROD_W'(TABLE_ENTRIES);
            end
            default:
            begin
                mul_a = PROD_W'(key);
                mul_b = PROD_W'(HOME_MULT);
            end
        endcase
        mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
    end

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        quot_next  = quot_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    acc_next   = mul_p[PROD_W-1:0];
                    phase_next = PH_RECIP;
                end
            end
            PH_RECIP:
            begin
                quot_next  = mul_p[MUL_W-1 -: PROD_W];
                phase_next = PH_BACK;
            end
            PH_BACK:
            begin
                acc_next   = acc_reg - mul_p[PROD_W-1:0];
                phase_next = PH_FIX;
            end
            PH_FIX:
            begin
                if (acc_reg >= PROD_W'(TABLE_ENTRIES))
                begin
                    acc_next = acc_reg - PROD_W'(TABLE_ENTRIES);
                end
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign slot = acc_reg[IDX_W-1:0];

endmodule

`default_nettype wire

// ===== sv/chht_mem.sv =====
// Slot store: one write port, one read port with registered read data.
// Entry layout from chht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chht_mem #(
    parameter int TABLE_ENTRIES = chht_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                               clk,
    input  wire logic                               rd_en,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0]   rd_addr,
    output chht_pkg::entry_t                        rd_data,
    input  wire logic                               wr_en,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0]   wr_addr,
    input  chht_pkg::entry_t                        wr_data
);
    import chht_pkg::*;

    entry_t mem_reg [TABLE_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/callsign_hash_table_top.sv =====
// Callsign hash table top: probe sequencer, key normalization, result register.
// Uses chht_pkg, chht_home and chht_mem.
//
//  channel  signals                                              direction
//  -------  ---------------------------------------------------  ---------
//  in       in_valid/in_stall, op, hash_kind, hash_value,         to block
//           name_head, name_tail
//  out      out_valid/out_stall, status, found_head, found_tail,  from block
//           entry_count
//
// Add/lookup: an accept step (key times 23), the reciprocal, back-multiply
// and fix steps of the modulo, a step to take the home slot, then a read and
// a compare per probe, a write for an insert and a result. Clear sweeps every
// slot; the same sweep runs after reset and in_stall stays high until it ends.
// The next beat is taken while a result waits on out_stall; a finished
// item holds in its result cycle until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module callsign_hash_table_top #(
    parameter int TABLE_ENTRIES = chht_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         op,
    input  wire logic [1:0]                         hash_kind,
    input  wire logic [chht_pkg::HASH_W-1:0]        hash_value,
    input  wire logic [chht_pkg::HEAD_W-1:0]        name_head,
    input  wire logic [chht_pkg::TAIL_W-1:0]        name_tail,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [chht_pkg::STATUS_W-1:0]           status,
    output logic [chht_pkg::HEAD_W-1:0]             found_head,
    output logic [chht_pkg::TAIL_W-1:0]             found_tail,
    output logic [chht_pkg::COUNT_W-1:0]            entry_count
);
    import chht_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int NAME_W = HEAD_W + TAIL_W;
    localparam int NAME_CHARS = NAME_W / 8;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HOME  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_CLEAR = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  probe_reg, probe_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              clr_reply_reg, clr_reply_next;
    logic              out_valid_reg, out_valid_next;

    logic              is_add_reg, is_add_next;
    logic [1:0]        kind_reg, kind_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [TAIL_W-1:0] tail_reg, tail_next;
    status_t           res_status_reg, res_status_next;
    logic [HEAD_W-1:0] res_head_reg, res_head_next;
    logic [TAIL_W-1:0] res_tail_reg, res_tail_next;

    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [HEAD_W-1:0]   out_head_reg, out_head_next;
    logic [TAIL_W-1:0]   out_tail_reg, out_tail_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic [NAME_W-1:0] name_norm;
    logic [HOME_W-1:0] home_key;
    logic              home_start;
    logic              home_done;
    logic [IDX_W-1:0]  home_slot;

    logic              mem_rd_en;
    logic              mem_wr_en;
    entry_t            mem_rd_data;
    entry_t            mem_wr_data;

    logic              slot_used;
    logic              dup_hit;
    logic              look_hit;
    logic [HASH_W-1:0] stored_shifted;
    logic              last_idx;
    logic [IDX_W-1:0]  idx_inc;

    // Zero every character after the first NUL.
    always_comb
    begin : normalize
        logic ended;
        ended     = 1'b0;
        name_norm = {name_head, name_tail};
        for (int k = NAME_CHARS - 1; k >= 0; k--)
        begin
            if (ended)
            begin
                name_norm[k*8 +: 8] = 8'h00;
            end
            else if (name_norm[k*8 +: 8] == 8'h00)
            begin
                ended = 1'b1;
            end
        end
    end

    // 10- and 12-bit lookup keys are narrower; their home bits sit lower in hash_value.
    always_comb
    begin
        home_key = hash_value[HASH_W-1 -: HOME_W];
        if (op == OP_LOOKUP)
        begin
            case (hash_kind)
                KIND_10: home_key = hash_value[HOME_W-1:0];
                KIND_12: home_key = hash_value[HOME_W+1:2];
                default: home_key = hash_value[HASH_W-1 -: HOME_W];
            endcase
        end
    end

    always_comb
    begin
        case (kind_reg)
            KIND_10: stored_shifted = mem_rd_data.hash >> 12;
            KIND_12: stored_shifted = mem_rd_data.hash >> 10;
            default: stored_shifted = mem_rd_data.hash;
        endcase
        slot_used = (mem_rd_data.head[HEAD_W-1 -: 8] != 8'h00);
        dup_hit   = (mem_rd_data.hash == hash_reg) && (mem_rd_data.head == head_reg)
                    && (mem_rd_data.tail == tail_reg);
        look_hit  = (stored_shifted == hash_reg);
        last_idx  = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));
        idx_inc   = last_idx ? '0 : idx_reg + IDX_W'(1);
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        probe_next      = probe_reg;
        count_next      = count_reg;
        clr_reply_next  = clr_reply_reg;
        out_valid_next  = out_valid_reg;
        is_add_next     = is_add_reg;
        kind_next       = kind_reg;
        hash_next       = hash_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        res_status_next = res_status_reg;
        res_head_next   = res_head_reg;
        res_tail_next   = res_tail_reg;
        out_status_next = out_status_reg;
        out_head_next   = out_head_reg;
        out_tail_next   = out_tail_reg;
        out_count_next  = out_count_reg;
        home_start      = 1'b0;
        mem_rd_en       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_data     = '{head: head_reg, tail: tail_reg, hash: hash_reg};

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    is_add_next     = (op == OP_ADD);
                    kind_next       = hash_kind;
                    hash_next       = hash_value;
                    head_next       = name_norm[NAME_W-1 -: HEAD_W];
                    tail_next       = name_norm[TAIL_W-1:0];
                    res_head_next   = '0;
                    res_tail_next   = '0;
                    res_status_next = ST_NOT_FOUND;
                    case (op)
                        OP_ADD:
                        begin
                            if (name_norm[NAME_W-1 -: 8] == 8'h00)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                home_start = 1'b1;
                                state_next = S_HOME;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            home_start = 1'b1;
                            state_next = S_HOME;
                        end
                        OP_CLEAR:
                        begin
                            idx_next       = '0;
                            clr_reply_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_HOME:
            begin
                if (home_done)
                begin
                    idx_next   = home_slot;
                    probe_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!slot_used)
                begin
                    state_next = is_add_reg ? S_WRITE : S_RESP;
                end
                else if (is_add_reg && dup_hit)
                begin
                    res_status_next = ST_DUPLICATE;
                    state_next      = S_RESP;
                end
                else if (!is_add_reg && look_hit)
                begin
                    res_status_next = ST_FOUND;
                    res_head_next   = mem_rd_data.head;
                    res_tail_next   = mem_rd_data.tail;
                    state_next      = S_RESP;
                end
                else if (probe_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    // every slot probed without an answer
                    res_status_next = is_add_reg ? ST_FULL : ST_NOT_FOUND;
                    state_next      = S_RESP;
                end
                else
                begin
                    probe_next = probe_reg + IDX_W'(1);
                    idx_next   = idx_inc;
                    state_next = S_READ;
                end
            end
            S_WRITE:
            begin
                mem_wr_en       = 1'b1;
                count_next      = count_reg + CNT_W'(1);
                res_status_next = ST_INSERTED;
                state_next      = S_RESP;
            end
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = '0;
                idx_next    = idx_inc;
                if (last_idx)
                begin
                    count_next      = '0;
                    clr_reply_next  = 1'b0;
                    res_status_next = ST_CLEARED;
                    state_next      = clr_reply_reg ? S_RESP : S_IDLE;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_head_next   = res_head_reg;
                    out_tail_next   = res_tail_reg;
                    out_count_next  = COUNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            probe_reg     <= '0;
            count_reg     <= '0;
            clr_reply_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            probe_reg     <= probe_next;
            count_reg     <= count_next;
            clr_reply_reg <= clr_reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_add_reg     <= is_add_next;
        kind_reg       <= kind_next;
        hash_reg       <= hash_next;
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        res_status_reg <= res_status_next;
        res_head_reg   <= res_head_next;
        res_tail_reg   <= res_tail_next;
        out_status_reg <= out_status_next;
        out_head_reg   <= out_head_next;
        out_tail_reg   <= out_tail_next;
        out_count_reg  <= out_count_next;
    end

    chht_home #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (home_start),
        .key   (home_key),
        .done  (home_done),
        .slot  (home_slot)
    );

    chht_mem #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (idx_reg),
        .wr_data (mem_wr_data)
    );

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_head  = out_head_reg;
    assign found_tail  = out_tail_reg;
    assign entry_count = out_count_reg;

endmodule

`default_nettype wire

// ===== tb/chht_result_check.sv =====
// Result checker for the callsign hash table: watches both channels, keeps its own
// copy of the slot store, predicts each result and compares it field by field.
// Depends on chht_pkg for widths, op, kind and status codes.
`timescale 1ns / 1ps

module chht_result_check
    import chht_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire logic [1:0]          op,
    input  wire logic [1:0]          hash_kind,
    input  wire logic [HASH_W-1:0]   hash_value,
    input  wire logic [HEAD_W-1:0]   name_head,
    input  wire logic [TAIL_W-1:0]   name_tail,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire logic [STATUS_W-1:0] status,
    input  wire logic [HEAD_W-1:0]   found_head,
    input  wire logic [TAIL_W-1:0]   found_tail,
    input  wire logic [COUNT_W-1:0]  entry_count,
    output int                       failures,
    output int                       pending,
    output int                       results_checked
);

    typedef struct {
        status_t            st;
        logic [HEAD_W-1:0]  head;
        logic [TAIL_W-1:0]  tail;
        logic [COUNT_W-1:0] cnt;
    } lookup_result_t;

    entry_t             store [TABLE_ENTRIES];
    logic [COUNT_W-1:0] used_count;
    lookup_result_t     awaited_results [$];
    lookup_result_t     want;

    initial
    begin
        failures = 0;
        pending = 0;
        results_checked = 0;
    end

    function automatic void wipe_store();
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            store[i] = '0;
        end
        used_count = '0;
    endfunction

    function automatic int home_slot(logic [HASH_W-1:0] bits);
        return (int'(bits[HOME_W-1:0]) * HOME_MULT) % TABLE_ENTRIES;
    endfunction

    // Applies one beat to the shadow store and returns the result it should produce.
    function automatic lookup_result_t table_apply(logic [1:0] cmd, logic [1:0] kind,
                                                   logic [HASH_W-1:0] key,
                                                   logic [HEAD_W-1:0] head,
                                                   logic [TAIL_W-1:0] tail);
        lookup_result_t r;
        int slot;
        int shift;
        int n;
        int k;
        logic ended;
        r.st = ST_NOT_FOUND;
        r.head = '0;
        r.tail = '0;
        case (cmd)
            OP_CLEAR:
            begin
                wipe_store();
                r.st = ST_CLEARED;
            end
            OP_ADD:
            begin
                // callsign stops at its first NUL; everything after counts as zero
                ended = 1'b0;
                for (k = 10; k >= 0; k--)
                begin
                    if (k >= 3)
                    begin
                        if (ended)
                            head[(k-3)*8 +: 8] = '0;
                        else if (head[(k-3)*8 +: 8] == 8'h00)
                            ended = 1'b1;
                    end
                    else
                    begin
                        if (ended)
                            tail[k*8 +: 8] = '0;
                        else if (tail[k*8 +: 8] == 8'h00)
                            ended = 1'b1;
                    end
                end
                if (head[HEAD_W-1 -: 8] != 8'h00)
                begin
                    slot = home_slot(key >> 12);
                    r.st = ST_FULL;
                    for (n = 0; n < TABLE_ENTRIES; n++)
                    begin
                        if (store[slot].head[HEAD_W-1 -: 8] == 8'h00)
                        begin
                            store[slot].head = head;
                            store[slot].tail = tail;
                            store[slot].hash = key;
                            used_count = used_count + 1'b1;
                            r.st = ST_INSERTED;
                            break;
                        end
                        if (store[slot].hash == key && store[slot].head == head &&
                            store[slot].tail == tail)
                        begin
                            r.st = ST_DUPLICATE;
                            break;
                        end
                        slot = (slot + 1) % TABLE_ENTRIES;
                    end
                end
            end
            OP_LOOKUP:
            begin
                case (kind)
                    KIND_10: shift = 12;
                    KIND_12: shift = 10;
                    default: shift = 0;
                endcase
                slot = home_slot(key >> (12 - shift));
                for (n = 0; n < TABLE_ENTRIES; n++)
                begin
                    if (store[slot].head[HEAD_W-1 -: 8] == 8'h00)
                        break;
                    if ((store[slot].hash >> shift) == key)
                    begin
                        r.st = ST_FOUND;
                        r.head = store[slot].head;
                        r.tail = store[slot].tail;
                        break;
                    end
                    slot = (slot + 1) % TABLE_ENTRIES;
                end
            end
            default:
            begin
            end
        endcase
        r.cnt = used_count;
        return r;
    endfunction

    task automatic report(string msg);
        $display("[%0t] check failed: %s", $time, msg);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_store();
            awaited_results.delete();
            pending = 0;
        end
        else
        begin
            // compare first: a result never belongs to a beat taken on the same edge
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    report($sformatf("result with nothing expected, status %0d count %0d",
                                     status, entry_count));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    results_checked++;
                    if (status !== want.st)
                        report($sformatf("status %0d, expected %0d", status, want.st));
                    if (found_head !== want.head)
                        report($sformatf("found_head %h, expected %h", found_head, want.head));
                    if (found_tail !== want.tail)
                        report($sformatf("found_tail %h, expected %h", found_tail, want.tail));
                    if (entry_count !== want.cnt)
                        report($sformatf("entry_count %0d, expected %0d",
                                         entry_count, want.cnt));
                end
            end
            if (in_valid && !in_stall)
            begin
                awaited_results.push_back(table_apply(op, hash_kind, hash_value,
                                                      name_head, name_tail));
            end
            pending = awaited_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the callsign hash table: clock, reset, stimulus and verdict.
// Depends on chht_pkg, callsign_hash_table_top and chht_result_check.
`timescale 1ns / 1ps

module tb;
    import chht_pkg::*;

    localparam int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES;
    localparam int ITEMS = 1700;
    // worst case about 1750 beats, each with a full-table probe walk, the longest gap and the longest stall
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    typedef struct {
        logic [HASH_W-1:0] hash;
        logic [HEAD_W-1:0] head;
        logic [TAIL_W-1:0] tail;
    } callsign_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                out_stall = 1'b0;
    logic [1:0]          op = '0;
    logic [1:0]          hash_kind = '0;
    logic [HASH_W-1:0]   hash_value = '0;
    logic [HEAD_W-1:0]   name_head = '0;
    logic [TAIL_W-1:0]   name_tail = '0;
    wire                 in_stall;
    wire                 out_valid;
    wire [STATUS_W-1:0]  status;
    wire [HEAD_W-1:0]    found_head;
    wire [TAIL_W-1:0]    found_tail;
    wire [COUNT_W-1:0]   entry_count;

    int failures;
    int pending;
    int results_checked;
    int cycle_count = 0;
    int beats_sent = 0;
    int adds = 0;
    int lookups = 0;
    int clears = 0;
    int others = 0;
    int fills = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;
    bit out_calm = 1'b0;
    bit filled_mid = 1'b0;
    callsign_t known [$];

    callsign_hash_table_top #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .hash_kind(hash_kind), .hash_value(hash_value),
        .name_head(name_head), .name_tail(name_tail),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .found_head(found_head), .found_tail(found_tail),
        .entry_count(entry_count)
    );

    chht_result_check #(.TABLE_ENTRIES(TABLE_ENTRIES)) result_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .hash_kind(hash_kind), .hash_value(hash_value),
        .name_head(name_head), .name_tail(name_tail),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .found_head(found_head), .found_tail(found_tail),
        .entry_count(entry_count),
        .failures(failures), .pending(pending), .results_checked(results_checked)
    );

    always #6 clk = ~clk;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("== FAIL ==");
        $finish;
    end

    // receiver backpressure: mostly free, short stalls, now and then a long one
    always @(negedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (out_calm || !idle_on)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (r < 75)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            out_stall <= 1'b1;
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic [1:0] o, logic [1:0] k, logic [HASH_W-1:0] h,
                             logic [HEAD_W-1:0] hd, logic [TAIL_W-1:0] tl);
        int gap;
        gap = sender_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        hash_kind <= k;
        hash_value <= h;
        name_head <= hd;
        name_tail <= tl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
        case (o)
            OP_ADD:    adds++;
            OP_LOOKUP: lookups++;
            OP_CLEAR:  clears++;
            default:   others++;
        endcase
    endtask

    // hold the sender off until every outstanding result is back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic make_callsign(output logic [HEAD_W-1:0] hd, output logic [TAIL_W-1:0] tl);
        logic [87:0] chars;
        int len;
        int style;
        int i;
        int r;
        style = $urandom_range(0, 9);
        chars = '0;
        if (style == 0)
        begin
            chars[87:64] = 24'($urandom);
            chars[63:32] = $urandom;
            chars[31:0] = $urandom;
        end
        else
        begin
            len = $urandom_range(1, 11);
            for (i = 0; i < len; i++)
            begin
                r = $urandom_range(0, 35);
                chars[87-8*i -: 8] = (r < 26) ? 8'(8'h41 + r) : 8'(8'h30 + r - 26);
            end
            // junk after the terminator
            if (style == 1)
            begin
                for (i = len + 1; i < 11; i++)
                    chars[87-8*i -: 8] = 8'($urandom_range(0, 255));
            end
        end
        hd = chars[87:24];
        tl = chars[23:0];
    endtask

    // most hashes crowd four home slots so probe chains grow long
    function automatic logic [HASH_W-1:0] pick_hash();
        if ($urandom_range(0, 9) < 6)
            return {10'($urandom_range(0, 3)), 12'($urandom_range(0, 4095))};
        return 22'($urandom);
    endfunction

    task automatic add_new();
        callsign_t c;
        c.hash = pick_hash();
        make_callsign(c.head, c.tail);
        known.push_back(c);
        send_item(OP_ADD, 2'($urandom_range(0, 3)), c.hash, c.head, c.tail);
    endtask

    task automatic readd_known();
        callsign_t c;
        c = known[$urandom_range(0, known.size() - 1)];
        send_item(OP_ADD, 2'($urandom_range(0, 3)), c.hash, c.head, c.tail);
    endtask

    task automatic lookup_known();
        callsign_t c;
        logic [1:0] k;
        logic [HASH_W-1:0] v;
        c = known[$urandom_range(0, known.size() - 1)];
        k = 2'($urandom_range(0, 3));
        case (k)
            KIND_10: v = c.hash >> 12;
            KIND_12: v = c.hash >> 10;
            default: v = c.hash;
        endcase
        // a bit above the lookup width must never match
        if (k != KIND_22 && k != KIND_RESERVED && $urandom_range(0, 9) == 0)
            v[$urandom_range(12, 21)] = 1'b1;
        send_item(OP_LOOKUP, k, v, {$urandom, $urandom}, 24'($urandom));
    endtask

    task automatic clear_store();
        send_item(OP_CLEAR, 2'($urandom_range(0, 3)), 22'($urandom), {$urandom, $urandom},
                  24'($urandom));
        known.delete();
    endtask

    task automatic run_traffic(int beats);
        int i;
        int r;
        for (i = 0; i < beats; i++)
        begin
            r = $urandom_range(0, 99);
            if (r >= 45 && r < 85 && known.size() == 0)
                r = 0;
            if (r < 45)
                add_new();
            else if (r < 55)
                readd_known();
            else if (r < 85)
                lookup_known();
            else if (r < 90)
                send_item(OP_LOOKUP, 2'($urandom_range(0, 3)), 22'($urandom),
                          {$urandom, $urandom}, 24'($urandom));
            else if (r < 95)
                send_item(OP_RESERVED, 2'($urandom_range(0, 3)), 22'($urandom),
                          {$urandom, $urandom}, 24'($urandom));
            else
                send_item(OP_ADD, 2'($urandom_range(0, 3)), 22'($urandom),
                          {8'h00, 24'($urandom), $urandom}, 24'($urandom));
        end
        if (known.size() > 200 || $urandom_range(0, 3) == 0)
            clear_store();
    endtask

    // fill every slot, then push on a full table: full, duplicate and long misses
    task automatic fill_store();
        clear_store();
        repeat (TABLE_ENTRIES + 8) add_new();
        repeat (8) readd_known();
        repeat (12) lookup_known();
        repeat (4)
            send_item(OP_LOOKUP, 2'($urandom_range(0, 3)), 22'($urandom),
                      {$urandom, $urandom}, 24'($urandom));
        drain_results();
        clear_store();
        fills++;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed beats
        send_item(OP_LOOKUP, KIND_22, 22'h0, '0, '0);
        send_item(OP_ADD, KIND_10, 22'h0, {8'h41, 56'h0}, 24'h0);
        send_item(OP_ADD, KIND_10, 22'h0, {8'h41, 56'h0}, 24'h0);
        send_item(OP_ADD, KIND_10, 22'h0, {8'h42, 56'h0}, 24'h0);
        send_item(OP_ADD, KIND_22, 22'h3FFFFF, {64{1'b1}}, {24{1'b1}});
        send_item(OP_ADD, KIND_22, 22'h3FFFFF, {8'h00, {56{1'b1}}}, {24{1'b1}});
        send_item(OP_ADD, KIND_22, 22'h12345,
                  {8'h41, 8'h42, 8'h00, 8'h58, 8'h59, 8'h5A, 8'h31, 8'h32}, 24'hFFFFFF);
        send_item(OP_ADD, KIND_22, 22'h12345, {8'h41, 8'h42, 48'h0}, 24'h0);
        send_item(OP_LOOKUP, KIND_10, 22'h3FF, '0, '0);
        send_item(OP_LOOKUP, KIND_12, 22'hFFF, '0, '0);
        send_item(OP_LOOKUP, KIND_22, 22'h3FFFFF, '0, '0);
        send_item(OP_LOOKUP, KIND_RESERVED, 22'h3FFFFF, '0, '0);
        send_item(OP_LOOKUP, KIND_10, 22'h2003FF, '0, '0);
        send_item(OP_LOOKUP, KIND_12, 22'h0, '0, '0);
        send_item(OP_LOOKUP, KIND_12, 22'h48, '0, '0);
        send_item(OP_RESERVED, KIND_RESERVED, {HASH_W{1'b1}}, {64{1'b1}}, {24{1'b1}});
        send_item(OP_CLEAR, KIND_10, 22'h0, '0, '0);
        send_item(OP_LOOKUP, KIND_10, 22'h0, '0, '0);
        drain_results();

        fill_store();
        while (beats_sent < ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (!filled_mid && beats_sent > ITEMS / 2)
            begin
                fill_store();
                filled_mid = 1'b1;
            end
            else
            begin
                run_traffic($urandom_range(20, 60));
            end
        end

        out_calm = 1'b1;
        drain_results();
        repeat (64) @(posedge clk);

        $display("sent %0d beats: %0d adds, %0d lookups, %0d clears, %0d reserved ops",
                 beats_sent, adds, lookups, clears, others);
        $display("store filled to capacity %0d times; %0d results compared, %0d failures",
                 fills, results_checked, failures);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
